FILE: rtl/bsa_pkg.sv
// shared types, constants and helpers for the bounded stack alu
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int STACK_DEPTH = 6;
  localparam int WORD_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int ITER_W      = $clog2(WORD_W);
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_W     = 3;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_PUSH = mode_t'(0);
  localparam mode_t MODE_POP  = mode_t'(1);
  localparam mode_t MODE_ADD  = mode_t'(2);
  localparam mode_t MODE_SUB  = mode_t'(3);
  localparam mode_t MODE_MUL  = mode_t'(4);
  localparam mode_t MODE_DIV  = mode_t'(5);

  localparam status_t ST_OK        = status_t'(0);
  localparam status_t ST_OVERFLOW  = status_t'(1);
  localparam status_t ST_UNDERFLOW = status_t'(2);
  localparam status_t ST_FEW       = status_t'(3);
  localparam status_t ST_DIVZERO   = status_t'(4);

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_NEG_L,
    A_NEG_R,
    A_LOOP,
    A_FIX,
    A_DONE
  } alu_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_TOP,
    S_RD_SEC,
    S_ALU,
    S_FIN
  } ctl_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    word_t   lhs;
    word_t   rhs;
  } alu_cmd_t;

  typedef struct packed {
    logic  done;
    word_t value;
  } alu_rsp_t;

  function automatic alu_op_t mode_to_op(input mode_t mode);
    alu_op_t op;
    case (mode)
      MODE_ADD: op = ALU_ADD;
      MODE_SUB: op = ALU_SUB;
      MODE_MUL: op = ALU_MUL;
      MODE_DIV: op = ALU_DIV;
      default:  op = ALU_ADD;
    endcase
    return op;
  endfunction

endpackage

FILE: rtl/bsa_stack_mem.sv
// operand stack storage: one write port, one registered read port
`timescale 1ns / 1ps

module bsa_stack_mem
  import bsa_pkg::*;
(
  input  logic  clk,
  input  logic  wr_en,
  input  idx_t  wr_addr,
  input  word_t wr_data,
  input  idx_t  rd_addr,
  output word_t rd_data
);

  word_t mem [STACK_DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/bsa_iter_alu.sv
// iterative alu: one shared adder does add, sub, shift-add multiply and restoring divide
`timescale 1ns / 1ps

module bsa_iter_alu
  import bsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_cmd_t cmd,
  output alu_rsp_t rsp
);

  alu_state_t        state_r, state_nxt;
  alu_op_t           op_r, op_nxt;
  word_t             a_r, a_nxt;
  word_t             b_r, b_nxt;
  word_t             acc_r, acc_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              negq_r, negq_nxt;

  logic [WORD_W:0] add_x, add_y, add_sum;
  logic            add_sub;
  logic [WORD_W:0] shifted;
  logic            borrow;
  logic            last_iter;

  // shared adder, also used as subtractor and negator
  assign add_sum   = add_x + (add_sub ? ~add_y : add_y) + {{WORD_W{1'b0}}, add_sub};
  assign shifted   = {acc_r, a_r[WORD_W-1]};
  assign borrow    = add_sum[WORD_W];
  assign last_iter = (cnt_r == ITER_W'(WORD_W - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE: begin
        if (cmd.start) begin
          state_nxt = (cmd.op == ALU_DIV) ? A_NEG_L : A_LOOP;
        end
      end
      A_NEG_L: state_nxt = A_NEG_R;
      A_NEG_R: state_nxt = A_LOOP;
      A_LOOP: begin
        case (op_r)
          ALU_MUL: state_nxt = last_iter ? A_DONE : A_LOOP;
          ALU_DIV: state_nxt = last_iter ? A_FIX : A_LOOP;
          default: state_nxt = A_DONE;
        endcase
      end
      A_FIX:   state_nxt = A_DONE;
      A_DONE:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_comb begin
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    negq_nxt = negq_r;
    add_x    = '0;
    add_y    = '0;
    add_sub  = 1'b0;
    case (state_r)
      A_IDLE: begin
        if (cmd.start) begin
          op_nxt   = cmd.op;
          a_nxt    = cmd.lhs;
          b_nxt    = cmd.rhs;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          negq_nxt = (cmd.op == ALU_DIV) && (cmd.lhs[WORD_W-1] ^ cmd.rhs[WORD_W-1]);
        end
      end
      A_NEG_L: begin
        add_y   = {1'b0, a_r};
        add_sub = 1'b1;
        if (a_r[WORD_W-1]) begin
          a_nxt = add_sum[WORD_W-1:0];
        end
      end
      A_NEG_R: begin
        add_y   = {1'b0, b_r};
        add_sub = 1'b1;
        if (b_r[WORD_W-1]) begin
          b_nxt = add_sum[WORD_W-1:0];
        end
      end
      A_LOOP: begin
        case (op_r)
          ALU_ADD, ALU_SUB: begin
            add_x   = {1'b0, a_r};
            add_y   = {1'b0, b_r};
            add_sub = (op_r == ALU_SUB);
            acc_nxt = add_sum[WORD_W-1:0];
          end
          ALU_MUL: begin
            add_x   = {1'b0, acc_r};
            add_y   = b_r[0] ? {1'b0, a_r} : '0;
            acc_nxt = add_sum[WORD_W-1:0];
            a_nxt   = {a_r[WORD_W-2:0], 1'b0};
            b_nxt   = {1'b0, b_r[WORD_W-1:1]};
            cnt_nxt = cnt_r + ITER_W'(1);
          end
          default: begin
            // restoring step: remainder in acc, quotient shifts into a
            add_x   = shifted;
            add_y   = {1'b0, b_r};
            add_sub = 1'b1;
            acc_nxt = borrow ? shifted[WORD_W-1:0] : add_sum[WORD_W-1:0];
            a_nxt   = {a_r[WORD_W-2:0], ~borrow};
            cnt_nxt = cnt_r + ITER_W'(1);
          end
        endcase
      end
      A_FIX: begin
        add_y   = {1'b0, a_r};
        add_sub = 1'b1;
        acc_nxt = negq_r ? add_sum[WORD_W-1:0] : a_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    negq_r <= negq_nxt;
  end

  assign rsp.done  = (state_r == A_DONE);
  assign rsp.value = acc_r;

endmodule

FILE: rtl/bounded_stack_alu_unit.sv
// top level: operand stack sequencer with iterative alu and output register
`timescale 1ns / 1ps

// Bounded operand stack with arithmetic on its top two entries.
// Input channel: in_valid/in_stall carry in_mode and in_push_value; an item
// is taken at an edge with in_valid high and in_stall low. in_stall is high
// while an item is being worked on.
// Result channel: out_valid/out_stall carry out_status, out_result_value,
// out_stack_depth and out_is_empty, one result per input item.
// The divide runs 32 restoring steps of the shared adder after two operand
// negations and before a quotient sign fix; the multiply runs 32 shift-add
// steps on the same adder. The stack memory has one read port, so the two
// operands are read one after the other, top first. The next item is
// accepted in the cycle after the result is loaded. A result held by a
// stalling receiver does not block the next item; that item only waits at
// the end for the output register to free up.
// Reset empties the stack and drops any pending result; stack contents
// are not cleared.
module bounded_stack_alu_unit
  import bsa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic signed [WORD_W-1:0]   in_push_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [WORD_W-1:0]   out_result_value,
  output logic [DEPTH_W-1:0]         out_stack_depth,
  output logic                       out_is_empty
);

  ctl_state_t state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  mode_t      mode_r;
  word_t      push_r;
  word_t      rhs_r, rhs_nxt;
  status_t    fin_status_r, fin_status_nxt;
  word_t      fin_value_r, fin_value_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r;
  word_t              out_value_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic               out_empty_r;

  logic     in_acc;
  logic     out_load;
  logic     is_arith;
  logic     is_full;
  logic     div_zero;
  cnt_t     cnt_m1, cnt_m2;
  logic     wr_en;
  idx_t     wr_addr, rd_addr;
  word_t    wr_data, rd_data;
  alu_cmd_t alu_cmd;
  alu_rsp_t alu_rsp;

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign is_arith = (mode_r >= MODE_ADD) && (mode_r <= MODE_DIV);
  assign is_full  = (count_r >= CNT_W'(STACK_DEPTH));
  assign div_zero = (mode_r == MODE_DIV) && (rhs_r == '0);
  assign cnt_m1   = count_r - CNT_W'(1);
  assign cnt_m2   = count_r - CNT_W'(2);

  bsa_stack_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bsa_iter_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (alu_cmd),
    .rsp   (alu_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (mode_r == MODE_POP) begin
          state_nxt = (count_r == '0) ? S_FIN : S_RD_TOP;
        end else if (is_arith) begin
          state_nxt = (count_r < CNT_W'(2)) ? S_FIN : S_RD_TOP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD_TOP: state_nxt = (mode_r == MODE_POP) ? S_FIN : S_RD_SEC;
      S_RD_SEC: state_nxt = div_zero ? S_FIN : S_ALU;
      S_ALU: begin
        if (alu_rsp.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != S_IDLE);
    count_nxt      = count_r;
    rhs_nxt        = rhs_r;
    fin_status_nxt = fin_status_r;
    fin_value_nxt  = fin_value_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];
    wr_data        = push_r;
    rd_addr        = (state_r == S_DECODE) ? cnt_m1[IDX_W-1:0] : cnt_m2[IDX_W-1:0];
    alu_cmd.start  = 1'b0;
    alu_cmd.op     = mode_to_op(mode_r);
    alu_cmd.lhs    = rd_data;
    alu_cmd.rhs    = rhs_r;
    case (state_r)
      S_DECODE: begin
        fin_status_nxt = ST_OK;
        fin_value_nxt  = '0;
        if (mode_r == MODE_PUSH) begin
          if (is_full) begin
            fin_status_nxt = ST_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (mode_r == MODE_POP) begin
          if (count_r == '0) begin
            fin_status_nxt = ST_UNDERFLOW;
          end
        end else if (is_arith && (count_r < CNT_W'(2))) begin
          fin_status_nxt = ST_FEW;
        end
      end
      S_RD_TOP: begin
        if (mode_r == MODE_POP) begin
          fin_value_nxt = rd_data;
          count_nxt     = cnt_m1;
        end else begin
          rhs_nxt = rd_data;
        end
      end
      S_RD_SEC: begin
        if (div_zero) begin
          fin_status_nxt = ST_DIVZERO;
        end else begin
          alu_cmd.start = 1'b1;
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          wr_en         = 1'b1;
          wr_addr       = cnt_m2[IDX_W-1:0];
          wr_data       = alu_rsp.value;
          count_nxt     = cnt_m1;
          fin_value_nxt = alu_rsp.value;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      mode_r <= in_mode;
      push_r <= $unsigned(in_push_value);
    end
    rhs_r        <= rhs_nxt;
    fin_status_r <= fin_status_nxt;
    fin_value_r  <= fin_value_nxt;
    if (out_load) begin
      out_status_r <= fin_status_r;
      out_value_r  <= fin_value_r;
      out_depth_r  <= DEPTH_W'(count_r);
      out_empty_r  <= (count_r == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = $signed(out_value_r);
  assign out_stack_depth  = out_depth_r;
  assign out_is_empty     = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result shown without finishing an item");

  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_value_r == '0)
    else $error("error result carries a nonzero value");

  a_alu_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == S_ALU)
    else $error("alu finished outside of an arithmetic item");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |=> $stable(count_r))
    else $error("stack count moved while no item was in work");

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the bounded stack alu with a shadow stack predictor
`timescale 1ns / 1ps

import bsa_pkg::*;

typedef struct {
  status_t              status;
  word_t                value;
  logic [DEPTH_W-1:0]   depth;
  logic                 empty;
} stack_result_t;

class stack_shadow;
  word_t           entries[STACK_DEPTH];
  int unsigned     depth;
  stack_result_t   pending_results[$];
  int unsigned     fails;

  function new();
    depth = 0;
    fails = 0;
  endfunction

  // apply one accepted item to the shadow stack and queue the result it causes
  function void apply_op(input mode_t mode, input word_t push_value);
    stack_result_t res;
    word_t lhs, rhs, mag_l, mag_r, quot, val;
    logic ok;
    res.status = ST_OK;
    res.value  = '0;
    if (mode == MODE_PUSH) begin
      if (depth >= STACK_DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        entries[depth] = push_value;
        depth++;
      end
    end else if (mode == MODE_POP) begin
      if (depth == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        depth--;
        res.value = entries[depth];
      end
    end else if (mode <= MODE_DIV) begin
      if (depth < 2) begin
        res.status = ST_FEW;
      end else begin
        rhs = entries[depth-1];
        lhs = entries[depth-2];
        ok  = 1'b1;
        val = '0;
        if (mode == MODE_ADD) begin
          val = lhs + rhs;
        end else if (mode == MODE_SUB) begin
          val = lhs - rhs;
        end else if (mode == MODE_MUL) begin
          val = lhs * rhs;
        end else if (rhs == '0) begin
          ok = 1'b0;
        end else begin
          // divide on magnitudes, then fix the sign; min / -1 wraps to min
          mag_l = lhs[WORD_W-1] ? -lhs : lhs;
          mag_r = rhs[WORD_W-1] ? -rhs : rhs;
          quot  = mag_l / mag_r;
          val   = (lhs[WORD_W-1] ^ rhs[WORD_W-1]) ? -quot : quot;
        end
        if (ok) begin
          depth--;
          entries[depth-1] = val;
          res.value = val;
        end else begin
          res.status = ST_DIVZERO;
        end
      end
    end
    res.depth = DEPTH_W'(depth);
    res.empty = (depth == 0);
    pending_results.push_back(res);
  endfunction

  function void check_result(input status_t status, input word_t value,
                             input logic [DEPTH_W-1:0] depth_out, input logic empty);
    stack_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no item pending: status %0d value %0d", status, $signed(value));
      fails++;
      return;
    end
    want = pending_results.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, status);
      fails++;
    end
    if (value !== want.value) begin
      $error("result_value: expected %0d, actual %0d", $signed(want.value), $signed(value));
      fails++;
    end
    if (depth_out !== want.depth) begin
      $error("stack_depth: expected %0d, actual %0d", want.depth, depth_out);
      fails++;
    end
    if (empty !== want.empty) begin
      $error("is_empty: expected %0d, actual %0d", want.empty, empty);
      fails++;
    end
  endfunction
endclass

module testbench;

  localparam mode_t       MODE_SPARE_A   = mode_t'(6);
  localparam mode_t       MODE_SPARE_B   = mode_t'(7);
  localparam mode_t       ARITH_OPS[4]   = '{MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV};
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 60;

  logic                      clk           = 1'b0;
  logic                      rst_n         = 1'b0;
  logic                      in_valid      = 1'b0;
  logic                      in_stall;
  logic [MODE_W-1:0]         in_mode       = MODE_PUSH;
  logic signed [WORD_W-1:0]  in_push_value = '0;
  logic                      out_valid;
  logic                      out_stall     = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic signed [WORD_W-1:0]  out_result_value;
  logic [DEPTH_W-1:0]        out_stack_depth;
  logic                      out_is_empty;

  int unsigned  in_idle_pct   = 0;
  int unsigned  out_stall_pct = 0;
  bit           hold_req      = 1'b0;
  int unsigned  quiet_cycles  = 0;
  stack_shadow  shadow        = new();

  bounded_stack_alu_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_stack_depth  (out_stack_depth),
    .out_is_empty     (out_is_empty)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_item(input mode_t mode, input word_t value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_push_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    shadow.apply_op(mode, value);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return '0;
      4:       return 32'h0000_0001;
      5, 6:    return word_t'($urandom_range(10)) - 5;
      default: return $urandom();
    endcase
  endfunction

  // mostly well-formed sequences steered by the current depth, a little noise
  function automatic mode_t pick_op(input int unsigned depth);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return mode_t'($urandom_range(7));
    if (depth < 2) return (roll < 85) ? MODE_PUSH : mode_t'($urandom_range(5));
    if (depth >= STACK_DEPTH) begin
      if (roll < 15) return MODE_PUSH;
      return (roll < 30) ? MODE_POP : ARITH_OPS[$urandom_range(3)];
    end
    if (roll < 45) return MODE_PUSH;
    if (roll < 55) return MODE_POP;
    return ARITH_OPS[$urandom_range(3)];
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned sent;
    mode_t mode;
    sent = 0;
    while (sent < count) begin
      mode = pick_op(shadow.depth);
      send_item(mode, pick_value());
      if (mode <= MODE_DIV) sent++;
    end
  endtask

  // receiver: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      shadow.check_result(out_status, out_result_value, out_stack_depth, out_is_empty);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // error paths on an empty or short stack, wrapping arithmetic
    send_item(MODE_POP,  '0);
    send_item(MODE_ADD,  '0);
    send_item(MODE_PUSH, 32'h7fff_ffff);
    send_item(MODE_SUB,  '0);
    send_item(MODE_PUSH, 32'h0000_0001);
    send_item(MODE_ADD,  '0);
    send_item(MODE_PUSH, 32'hffff_ffff);
    send_item(MODE_DIV,  32'hffff_ffff);
    send_item(MODE_PUSH, '0);
    send_item(MODE_DIV,  '0);
    send_item(MODE_POP,  '0);
    send_item(MODE_PUSH, 32'h0000_0003);
    send_item(MODE_MUL,  '0);
    send_item(MODE_PUSH, 32'hffff_fffe);
    send_item(MODE_SUB,  '0);
    // fill to the top, then push once more
    send_item(MODE_PUSH, 32'hffff_fff9);
    send_item(MODE_PUSH, 32'h0000_0002);
    send_item(MODE_PUSH, 32'h8000_0000);
    send_item(MODE_PUSH, 32'haaaa_aaaa);
    send_item(MODE_PUSH, 32'h5555_5555);
    send_item(MODE_PUSH, 32'h1234_5678);
    send_item(MODE_SPARE_A, 32'hffff_ffff);
    send_item(MODE_SPARE_B, '0);
    send_item(MODE_MUL,  '0);
    send_item(MODE_SUB,  '0);
    send_item(MODE_POP,  '0);
    // negative over positive truncates toward zero
    send_item(MODE_DIV,  '0);

    in_idle_pct = 0;  out_stall_pct = 0;
    run_random(100);
    hold_req = 1'b1;
    run_random(60);

    in_idle_pct = 80; out_stall_pct = 0;
    run_random(160);

    in_idle_pct = 0;  out_stall_pct = 80;
    run_random(160);

    in_idle_pct = 12; out_stall_pct = 12;
    run_random(180);

    in_idle_pct = 0;  out_stall_pct = 0;
    run_random(160);

    in_valid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bsa_pkg.sv
rtl/bsa_stack_mem.sv
rtl/bsa_iter_alu.sv
rtl/bounded_stack_alu_unit.sv
sim/testbench.sv
